FILE: rtl/multipath_min_rtt_scheduler_macros.svh
// assertion helpers for the path scheduler, sampled on clk, off while in reset
`ifndef MULTIPATH_MIN_RTT_SCHEDULER_MACROS_SVH
`define MULTIPATH_MIN_RTT_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MMRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mmrs_pkg.sv
`default_nettype none

package mmrs_pkg;

  localparam int RTT_W  = 31;
  localparam int CNT_W  = 4;
  localparam int SLOT_W = 3;
  localparam int EIDX_W = 3;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCHED_MODE = 1'b0,
    CFG_SLOT_COUNT = 1'b1
  } cfg_idx_t;

  // request kinds on the input channel
  typedef enum logic {
    REQ_SELECT = 1'b0,
    REQ_WRITE  = 1'b1
  } req_type_t;

  // scheduling policies
  typedef enum logic {
    MODE_MIN_RTT   = 1'b0,
    MODE_REDUNDANT = 1'b1
  } sched_mode_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_DONE
  } eng_state_t;

  // control from the top level into the sequencer
  typedef struct packed {
    logic              start;
    logic              take;
    sched_mode_t       mode;
    logic [CNT_W-1:0]  slot_count;
  } sched_cmd_t;

  // status from the sequencer back to the top level
  typedef struct packed {
    logic              idle;
    logic              res_valid;
    logic              res_none;
    logic [SLOT_W-1:0] res_slot;
  } sched_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mmrs_alu.sv
`default_nettype none

// shared compare and subtract unit
module mmrs_alu (
  input  wire logic [mmrs_pkg::RTT_W-1:0] a,
  input  wire logic [mmrs_pkg::RTT_W-1:0] b,
  output logic                            lt,
  output logic                            eq,
  output logic [mmrs_pkg::RTT_W-1:0]      diff
);
  import mmrs_pkg::*;

  logic [RTT_W:0] sub;

  // one subtractor gives order and difference
  assign sub  = {1'b0, a} - {1'b0, b};
  assign lt   = sub[RTT_W];
  assign eq   = (a == b);
  assign diff = sub[RTT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/mmrs_slot_tbl.sv
`default_nettype none

// path slot table: one write port, one read port, flag vectors
module mmrs_slot_tbl #(
  parameter int MAX_PATHS = 8,
  localparam int IW = $clog2(MAX_PATHS)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [mmrs_pkg::EIDX_W-1:0]      wr_idx,
  input  wire logic                             wr_active,
  input  wire logic                             wr_backup,
  input  wire logic [mmrs_pkg::RTT_W-1:0]       wr_rtt,
  input  wire logic [IW-1:0]                    rd_addr,
  output logic                                  rd_in_use,
  output logic                                  rd_backup,
  output logic [mmrs_pkg::RTT_W-1:0]            rd_rtt,
  output logic [MAX_PATHS-1:0]                  in_use_vec,
  output logic [MAX_PATHS-1:0]                  backup_vec
);
  import mmrs_pkg::*;

  logic [MAX_PATHS-1:0] in_use_r;
  logic [MAX_PATHS-1:0] backup_r;
  logic [RTT_W-1:0]     rtt_r [MAX_PATHS];
  logic                 wr_ok;
  logic [IW-1:0]        wr_addr;

  // writes beyond the table are dropped
  assign wr_ok   = wr_en && (32'(wr_idx) < MAX_PATHS);
  assign wr_addr = IW'(wr_idx);

  // flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      backup_r <= '0;
    end else if (wr_ok) begin
      in_use_r[wr_addr] <= wr_active;
      backup_r[wr_addr] <= wr_backup;
    end
  end

  // rtt values, only read for slots in use
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      rtt_r[wr_addr] <= wr_rtt;
    end
  end

  assign rd_in_use  = in_use_r[rd_addr];
  assign rd_backup  = backup_r[rd_addr];
  assign rd_rtt     = rtt_r[rd_addr];
  assign in_use_vec = in_use_r;
  assign backup_vec = backup_r;

endmodule

`default_nettype wire

FILE: rtl/mmrs_engine.sv
`default_nettype none

// select sequencer: walks the slots one per cycle through the shared unit
module mmrs_engine #(
  parameter int MAX_PATHS = 8,
  localparam int IW = $clog2(MAX_PATHS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mmrs_pkg::sched_cmd_t        cmd,
  output mmrs_pkg::sched_stat_t            stat,
  output logic [IW-1:0]                    rd_addr,
  input  wire logic                        rd_in_use,
  input  wire logic                        rd_backup,
  input  wire logic [mmrs_pkg::RTT_W-1:0]  rd_rtt,
  input  wire logic [MAX_PATHS-1:0]        in_use_vec,
  input  wire logic [MAX_PATHS-1:0]        backup_vec
);
  import mmrs_pkg::*;

  localparam int MW = IW + 1;

  eng_state_t       state_r, state_nxt;
  sched_mode_t      mode_r, mode_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [IW-1:0]    ptr_r, ptr_nxt;
  logic [MW-1:0]    m_r, m_nxt;
  logic             any_prim_r, any_prim_nxt;
  logic [RTT_W-1:0] best_r, best_nxt;
  logic             found_r, found_nxt;
  logic [IW-1:0]    low_r, low_nxt;
  logic             after_vld_r, after_vld_nxt;
  logic [IW-1:0]    after_r, after_nxt;
  logic             res_none_r, res_none_nxt;
  logic [IW-1:0]    res_idx_r, res_idx_nxt;
  logic [IW-1:0]    last_pick_r, last_pick_nxt;

  logic [CNT_W-1:0] n_clamp;
  logic             any_prim;
  logic [RTT_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_lt, alu_eq;
  logic             elig, above, hit, last_k, scan_end;

  // scanned slot count, limited to the table size
  assign n_clamp = (32'(cmd.slot_count) > MAX_PATHS) ? CNT_W'(MAX_PATHS) : cmd.slot_count;

  // any in-use primary slot within the scanned range
  always_comb begin
    any_prim = 1'b0;
    for (int i = 0; i < MAX_PATHS; i++) begin
      if ((i < 32'(n_clamp)) && in_use_vec[i] && !backup_vec[i]) begin
        any_prim = 1'b1;
      end
    end
  end

  // operand select for the shared unit
  always_comb begin
    alu_a = rd_rtt;
    alu_b = best_r;
    if (state_r == ST_REDUCE) begin
      alu_a = RTT_W'(m_r);
      alu_b = RTT_W'(n_r);
    end
  end

  mmrs_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .lt   (alu_lt),
    .eq   (alu_eq),
    .diff (alu_diff)
  );

  assign rd_addr = ptr_r;

  // per-slot decisions during the scan
  assign elig     = rd_in_use && !(any_prim_r && rd_backup);
  assign above    = ptr_r > last_pick_r;
  assign hit      = rd_in_use && !rd_backup && (ptr_r != last_pick_r);
  assign last_k   = (k_r == (n_r - CNT_W'(1)));
  assign scan_end = last_k || ((mode_r == MODE_REDUNDANT) && hit);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          if (n_clamp == '0) begin
            state_nxt = ST_DONE;
          end else if (cmd.mode == MODE_REDUNDANT) begin
            state_nxt = ST_REDUCE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_REDUCE: begin
        if (alu_lt) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (cmd.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    mode_nxt      = mode_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    m_nxt         = m_r;
    any_prim_nxt  = any_prim_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    low_nxt       = low_r;
    after_vld_nxt = after_vld_r;
    after_nxt     = after_r;
    res_none_nxt  = res_none_r;
    res_idx_nxt   = res_idx_r;
    last_pick_nxt = last_pick_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          mode_nxt      = cmd.mode;
          n_nxt         = n_clamp;
          k_nxt         = '0;
          ptr_nxt       = '0;
          m_nxt         = MW'(last_pick_r) + MW'(1);
          any_prim_nxt  = any_prim;
          found_nxt     = 1'b0;
          after_vld_nxt = 1'b0;
          res_none_nxt  = 1'b1;
          res_idx_nxt   = '0;
        end
      end
      // start index of the rotation: (last_pick + 1) mod n
      ST_REDUCE: begin
        if (!alu_lt) begin
          m_nxt = MW'(alu_diff);
        end else begin
          ptr_nxt = IW'(m_r);
        end
      end
      ST_SCAN: begin
        k_nxt   = k_r + CNT_W'(1);
        ptr_nxt = ((32'(ptr_r) + 32'd1) == 32'(n_r)) ? '0 : ptr_r + IW'(1);
        if (mode_r == MODE_MIN_RTT) begin
          // lowest rtt, ties go to the first slot above the last pick, else the lowest tied slot
          if (elig) begin
            if (!found_r || alu_lt) begin
              best_nxt      = rd_rtt;
              found_nxt     = 1'b1;
              low_nxt       = ptr_r;
              after_vld_nxt = above;
              after_nxt     = ptr_r;
            end else if (alu_eq && !after_vld_r && above) begin
              after_vld_nxt = 1'b1;
              after_nxt     = ptr_r;
            end
          end
          if (last_k) begin
            res_none_nxt = !found_nxt;
            res_idx_nxt  = after_vld_nxt ? after_nxt : low_nxt;
          end
        end else begin
          // found and low hold the first in-use slot of the rotation
          if (rd_in_use && !found_r) begin
            found_nxt = 1'b1;
            low_nxt   = ptr_r;
          end
          if (hit) begin
            res_none_nxt = 1'b0;
            res_idx_nxt  = ptr_r;
          end else if (last_k) begin
            res_none_nxt = !found_nxt;
            res_idx_nxt  = low_nxt;
          end
        end
      end
      ST_DONE: begin
        if (cmd.take && !res_none_r) begin
          last_pick_nxt = res_idx_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_pick_r <= '0;
    end else begin
      state_r     <= state_nxt;
      last_pick_r <= last_pick_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    ptr_r       <= ptr_nxt;
    m_r         <= m_nxt;
    any_prim_r  <= any_prim_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    low_r       <= low_nxt;
    after_vld_r <= after_vld_nxt;
    after_r     <= after_nxt;
    res_none_r  <= res_none_nxt;
    res_idx_r   <= res_idx_nxt;
  end

  // status to the top level
  always_comb begin
    stat.idle      = (state_r == ST_IDLE);
    stat.res_valid = (state_r == ST_DONE);
    stat.res_none  = res_none_r;
    stat.res_slot  = res_none_r ? '0 : SLOT_W'(32'(res_idx_r));
  end

endmodule

`default_nettype wire

FILE: rtl/multipath_min_rtt_scheduler.sv
// write request: no result; select request: the slot scan walks one
// slot per cycle through a shared compare/subtract unit, n = min(slot_count, MAX_PATHS).
// min-rtt select: all n slots are scanned (no scan when n = 0); redundant: (last_pick + 1)
// is first reduced modulo n by repeated subtraction, then the scan stops at the first hit or after n slots.
// in_ready returns the cycle after a result is registered; a held output stalls the next result.
// synchronous active-low reset clears flags, last pick and configuration.
`default_nettype none

`include "multipath_min_rtt_scheduler_macros.svh"

module multipath_min_rtt_scheduler #(
  parameter int MAX_PATHS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [mmrs_pkg::CNT_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_req_type,
  input  wire logic [mmrs_pkg::EIDX_W-1:0]   in_entry_index,
  input  wire logic                          in_entry_active,
  input  wire logic                          in_entry_backup,
  input  wire logic [mmrs_pkg::RTT_W-1:0]    in_entry_rtt,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mmrs_pkg::SLOT_W-1:0]        out_chosen_slot,
  output logic                               out_no_path
);
  import mmrs_pkg::*;

  localparam int IW = $clog2(MAX_PATHS);

  sched_mode_t          sched_mode_r;
  logic [CNT_W-1:0]     slot_count_r;
  logic                 out_valid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_none_r;
  sched_cmd_t           cmd;
  sched_stat_t          stat;
  logic                 in_xfer;
  logic                 res_take;
  logic [IW-1:0]        rd_addr;
  logic                 rd_in_use, rd_backup;
  logic [RTT_W-1:0]     rd_rtt;
  logic [MAX_PATHS-1:0] in_use_vec, backup_vec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_mode_r <= MODE_MIN_RTT;
      slot_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCHED_MODE: sched_mode_r <= sched_mode_t'(cfg_wdata[0]);
        CFG_SLOT_COUNT: slot_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_ready = stat.idle;
  assign in_xfer  = in_valid && in_ready;
  assign res_take = stat.res_valid && (!out_valid_r || out_ready);

  always_comb begin
    cmd.start      = in_xfer && (in_req_type == REQ_SELECT);
    cmd.take       = res_take;
    cmd.mode       = sched_mode_r;
    cmd.slot_count = slot_count_r;
  end

  mmrs_slot_tbl #(.MAX_PATHS(MAX_PATHS)) u_tbl (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_xfer && (in_req_type == REQ_WRITE)),
    .wr_idx     (in_entry_index),
    .wr_active  (in_entry_active),
    .wr_backup  (in_entry_backup),
    .wr_rtt     (in_entry_rtt),
    .rd_addr    (rd_addr),
    .rd_in_use  (rd_in_use),
    .rd_backup  (rd_backup),
    .rd_rtt     (rd_rtt),
    .in_use_vec (in_use_vec),
    .backup_vec (backup_vec)
  );

  mmrs_engine #(.MAX_PATHS(MAX_PATHS)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .rd_addr    (rd_addr),
    .rd_in_use  (rd_in_use),
    .rd_backup  (rd_backup),
    .rd_rtt     (rd_rtt),
    .in_use_vec (in_use_vec),
    .backup_vec (backup_vec)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_slot_r <= stat.res_slot;
      out_none_r <= stat.res_none;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_slot = out_slot_r;
  assign out_no_path     = out_none_r;

  // checks
  `MMRS_ASSERT_NOW(a_nopath_slot_zero, out_valid && out_no_path, out_chosen_slot == '0, "no-path result carries a nonzero slot")
  `MMRS_ASSERT_NEXT(a_select_busy, in_valid && in_ready && (in_req_type == REQ_SELECT), !in_ready, "ready stayed high after a select transfer")
  `MMRS_ASSERT_NEXT(a_write_silent, in_valid && in_ready && (in_req_type == REQ_WRITE) && !out_valid, !out_valid, "write request produced a result")

endmodule

`default_nettype wire

FILE: tb/mmrs_pick_monitor.sv
module mmrs_pick_monitor
  import mmrs_pkg::*;
#(
  parameter int MAX_PATHS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CNT_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_req_type,
  input  logic [EIDX_W-1:0]   in_entry_index,
  input  logic                in_entry_active,
  input  logic                in_entry_backup,
  input  logic [RTT_W-1:0]    in_entry_rtt,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SLOT_W-1:0]   out_chosen_slot,
  input  logic                out_no_path,
  output int                  fail_count,
  output int                  pending_picks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              no_path;
    logic [SLOT_W-1:0] slot;
  } pick_t;

  // picks still owed by the block, oldest first
  pick_t expected_picks [$];

  // local copy of the path table and scheduler registers
  logic             path_up     [MAX_PATHS];
  logic             path_backup [MAX_PATHS];
  logic [RTT_W-1:0] path_rtt    [MAX_PATHS];
  int               prev_pick;
  sched_mode_t      policy;
  logic [CNT_W-1:0] slots_cfg;
  int               failures;

  function automatic void flag(string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // slots taking part in a select, clamped to the table size
  function automatic int scan_len();
    return (int'(slots_cfg) > MAX_PATHS) ? MAX_PATHS : int'(slots_cfg);
  endfunction

  // lowest rtt among primaries, or among all in-use slots when no primary is up;
  // ties go to the first tied slot above the previous pick, else the lowest one
  function automatic int lowest_rtt_slot(int n);
    bit               any_primary = 1'b0;
    bit               found = 1'b0;
    logic [RTT_W-1:0] best = '0;
    int               after = -1;
    int               lowest = -1;
    for (int i = 0; i < n; i++)
      if (path_up[i] && !path_backup[i]) any_primary = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!path_up[i] || (any_primary && path_backup[i])) continue;
      if (!found || path_rtt[i] < best) begin
        best  = path_rtt[i];
        found = 1'b1;
      end
    end
    if (!found) return -1;
    for (int i = 0; i < n; i++) begin
      if (!path_up[i] || (any_primary && path_backup[i])) continue;
      if (path_rtt[i] != best) continue;
      if (lowest < 0) lowest = i;
      if (after < 0 && i > prev_pick) after = i;
    end
    return (after >= 0) ? after : lowest;
  endfunction

  // round robin from the slot after the previous pick, wrapping at n
  function automatic int rotate_slot(int n);
    int first_up = -1;
    int idx;
    for (int k = 0; k < n; k++) begin
      idx = (prev_pick + 1 + k) % n;
      if (!path_up[idx]) continue;
      if (first_up < 0) first_up = idx;
      if (!path_backup[idx] && idx != prev_pick) return idx;
    end
    return first_up;
  endfunction

  always @(posedge clk) begin : track
    pick_t got;
    pick_t want;
    int    n;
    int    pick;
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATHS; i++) begin
        path_up[i]     = 1'b0;
        path_backup[i] = 1'b0;
        path_rtt[i]    = '0;
      end
      prev_pick = 0;
      policy    = MODE_MIN_RTT;
      slots_cfg = '0;
      expected_picks.delete();
    end else begin
      // result transfer: compare against the oldest owed pick
      if (out_valid && out_ready) begin
        got.no_path = out_no_path;
        got.slot    = out_chosen_slot;
        if (expected_picks.size() == 0) begin
          flag($sformatf("unexpected result: slot=%0d no_path=%0b", got.slot, got.no_path));
        end else begin
          want = expected_picks.pop_front();
          if (got.no_path !== want.no_path || got.slot !== want.slot)
            flag($sformatf("pick mismatch: expected slot=%0d no_path=%0b, %s",
                           want.slot, want.no_path,
                           $sformatf("got slot=%0d no_path=%0b", got.slot, got.no_path)));
        end
      end

      // request transfer: update the table or predict a pick
      if (in_valid && in_ready) begin
        if (req_type_t'(in_req_type) == REQ_WRITE) begin
          if (int'(in_entry_index) < MAX_PATHS) begin
            path_up[in_entry_index]     = in_entry_active;
            path_backup[in_entry_index] = in_entry_backup;
            path_rtt[in_entry_index]    = in_entry_rtt;
          end
        end else begin
          n    = scan_len();
          pick = -1;
          if (n > 0) pick = (policy == MODE_REDUNDANT) ? rotate_slot(n) : lowest_rtt_slot(n);
          if (pick < 0) begin
            want.no_path = 1'b1;
            want.slot    = '0;
          end else begin
            prev_pick    = pick;
            want.no_path = 1'b0;
            want.slot    = SLOT_W'(pick);
          end
          expected_picks.push_back(want);
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SCHED_MODE: policy    = sched_mode_t'(cfg_wdata[0]);
          CFG_SLOT_COUNT: slots_cfg = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending_picks <= expected_picks.size();
    fail_count    <= failures;
  end

endmodule

FILE: tb/multipath_min_rtt_scheduler_tb.sv
module multipath_min_rtt_scheduler_tb
  import mmrs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 70;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = '0;
  logic [CNT_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic [EIDX_W-1:0]    in_entry_index = '0;
  logic                 in_entry_active = 1'b0;
  logic                 in_entry_backup = 1'b0;
  logic [RTT_W-1:0]     in_entry_rtt = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SLOT_W-1:0]    out_chosen_slot;
  logic                 out_no_path;

  int fail_count;
  int pending_picks;
  int burst_left = 0;
  bit steady = 1'b0;
  int hold_request = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multipath_min_rtt_scheduler #(.MAX_PATHS(8)) DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_req_type, .in_entry_index, .in_entry_active,
    .in_entry_backup, .in_entry_rtt,
    .out_valid, .out_ready, .out_chosen_slot, .out_no_path
  );

  mmrs_pick_monitor #(.MAX_PATHS(8)) pick_monitor (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_req_type, .in_entry_index, .in_entry_active,
    .in_entry_backup, .in_entry_rtt,
    .out_valid, .out_ready, .out_chosen_slot, .out_no_path,
    .fail_count, .pending_picks
  );

  // one request transfer, with random gaps between bursts unless held steady
  task automatic offer(req_type_t kind, logic [EIDX_W-1:0] idx, logic act, logic bak,
                       logic [RTT_W-1:0] rtt);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_entry_index  <= idx;
    in_entry_active <= act;
    in_entry_backup <= bak;
    in_entry_rtt    <= rtt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_slot(logic [EIDX_W-1:0] idx, logic act, logic bak, logic [RTT_W-1:0] rtt);
    offer(REQ_WRITE, idx, act, bak, rtt);
  endtask

  // select with random content in the fields it ignores
  task automatic select_path();
    offer(REQ_SELECT, EIDX_W'($urandom), 1'($urandom), 1'($urandom), RTT_W'($urandom));
  endtask

  // stop sending, wait for every owed pick, then let the block go quiet
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_picks != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [CNT_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly selects and table updates, rtt drawn to make ties frequent
  task automatic random_item();
    logic [RTT_W-1:0] rtt;
    case ($urandom_range(0, 5))
      0: rtt = '0;
      1: rtt = '1;
      2, 3: rtt = RTT_W'($urandom_range(1, 4));
      default: rtt = RTT_W'($urandom);
    endcase
    if (steady || $urandom_range(0, 1) == 0)
      select_path();
    else
      write_slot(EIDX_W'($urandom), $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0, rtt);
  endtask

  // receiver: stall patterns of random length, plus long hold-offs on request
  initial begin : receiver
    int         hold_left;
    int         hold_served;
    int         pat_left;
    int         pat_pos;
    logic [7:0] stall_mask;
    hold_left   = 0;
    hold_served = 0;
    pat_left    = 0;
    pat_pos     = 0;
    stall_mask  = '0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_request) begin
        hold_served = hold_request;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_left = $urandom_range(16, 128);
          case ($urandom_range(0, 3))
            0: stall_mask = 8'h00;
            1: stall_mask = 8'h55;
            default: stall_mask = 8'($urandom) & 8'h7f;
          endcase
        end
        pat_left--;
        pat_pos = (pat_pos + 1) % 8;
        out_ready <= !stall_mask[pat_pos];
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    sched_mode_t phase_policy [PHASES];
    int          phase_slots  [PHASES];
    phase_policy = '{MODE_MIN_RTT, MODE_REDUNDANT, MODE_MIN_RTT, MODE_REDUNDANT, MODE_MIN_RTT,
                     MODE_REDUNDANT, MODE_MIN_RTT, MODE_REDUNDANT, MODE_MIN_RTT};
    phase_slots  = '{8, 8, 4, 2, 15, 15, 1, 5, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no slots scanned right after reset
    select_path();
    set_reg(CFG_SLOT_COUNT, 4'd8);
    // nothing in use
    select_path();
    // largest rtt on a lone primary
    write_slot(3'd7, 1'b1, 1'b0, '1);
    select_path();
    // backup with zero rtt loses to any primary
    write_slot(3'd0, 1'b1, 1'b1, '0);
    select_path();
    // tie with nothing above the last pick wraps to the lowest tied slot
    write_slot(3'd3, 1'b1, 1'b0, '1);
    select_path();
    select_path();
    // unmeasured rtt is the lowest
    write_slot(3'd5, 1'b1, 1'b0, '0);
    select_path();
    // only backups left
    write_slot(3'd5, 1'b0, 1'b0, '0);
    write_slot(3'd3, 1'b0, 1'b0, '1);
    write_slot(3'd7, 1'b0, 1'b0, '1);
    select_path();
    // tie among backups
    write_slot(3'd2, 1'b1, 1'b1, '0);
    select_path();
    select_path();

    // redundant mode, count beyond the table
    set_reg(CFG_SCHED_MODE, {3'($urandom), MODE_REDUNDANT});
    set_reg(CFG_SLOT_COUNT, 4'd15);
    write_slot(3'd4, 1'b1, 1'b0, RTT_W'($urandom));
    select_path();
    select_path();
    select_path();
    // last pick outside the scanned range
    set_reg(CFG_SLOT_COUNT, 4'd3);
    select_path();
    set_reg(CFG_SLOT_COUNT, 4'd1);
    select_path();

    // random phases over a spread of settings
    for (int p = 0; p < PHASES; p++) begin
      set_reg(CFG_SCHED_MODE, {3'($urandom), phase_policy[p]});
      set_reg(CFG_SLOT_COUNT, CNT_W'(phase_slots[p]));
      if (p == 1) begin
        // long receiver hold-off while selects keep coming
        hold_request++;
        steady = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (steady && i == 40) steady = 1'b0;
        random_item();
        if (!steady && $urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0 && pending_picks == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: multipath_min_rtt_scheduler.f
+incdir+rtl
rtl/mmrs_pkg.sv
rtl/mmrs_alu.sv
rtl/mmrs_slot_tbl.sv
rtl/mmrs_engine.sv
rtl/multipath_min_rtt_scheduler.sv
tb/mmrs_pick_monitor.sv
tb/multipath_min_rtt_scheduler_tb.sv
